>>> design/dqp_pkg.sv
// ----------------------------------------------------------------------------
// dqp_pkg: shared types and constants for the DNS query parser
// Parse phases, status codes, header offsets and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package dqp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LEN    = 3'd1,
		PH_LABEL  = 3'd2,
		PH_TAIL   = 3'd3,
		PH_IGNORE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_NOT_ONE  = 2'd2,
		ST_NAME_OVF = 2'd3
	} status_t;

	// header byte offsets
	localparam int POS_FLAGS   = 2;
	localparam int POS_QD_HI   = 4;
	localparam int POS_QD_LO   = 5;
	localparam int POS_AR_HI   = 10;
	localparam int POS_AR_LO   = 11;

	// offsets after the root byte of the question name
	localparam logic [3:0] TAIL_OPT_NAME = 4'd4;
	localparam logic [3:0] TAIL_TYPE_HI  = 4'd5;
	localparam logic [3:0] TAIL_TYPE_LO  = 4'd6;
	localparam logic [3:0] TAIL_SIZE_HI  = 4'd7;
	localparam logic [3:0] TAIL_SIZE_LO  = 4'd8;

	localparam logic [7:0] OPT_TYPE_LO  = 8'h29;
	localparam logic [7:0] UDP_SIZE_HI  = 8'h10;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;
	localparam logic [9:0] NAME_LEN_RST = 10'd512;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       name_valid;
		logic [7:0] name_char;
		logic       done_res;
		status_t    status;
	} res_t;

endpackage

`default_nettype wire

>>> design/dqp_front.sv
// ----------------------------------------------------------------------------
// dqp_front: byte classifier and parse state
// Tracks header, label walk and EDNS0 tail; builds one result word per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_front import dqp_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [9:0] cfg_wdata,
	input  wire logic       in_fire,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output res_t            res
);

	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

	logic [9:0]       max_len_q;
	logic [POS_W-1:0] pos_q, pos_d;
	phase_t           phase_q, phase_d;
	logic [7:0]       lbl_left_q, lbl_left_d;
	logic [9:0]       used_q, used_d;
	logic             hdr_bad_q, hdr_bad_d;
	logic             ar_q, ar_d;
	logic [3:0]       tail_q, tail_d;
	logic             opt_q, opt_d;
	logic             bump_q, bump_d;
	logic             ovf_q, ovf_d;
	logic [10:0]      len_sum;
	logic [7:0]       lbl_dec;

	assign len_sum = {1'b0, used_q} + {3'b0, in_byte} + 11'd1;
	assign lbl_dec = lbl_left_q - 8'd1;

	always_comb begin
		pos_d      = pos_q;
		phase_d    = phase_q;
		lbl_left_d = lbl_left_q;
		used_d     = used_q;
		hdr_bad_d  = hdr_bad_q;
		ar_d       = ar_q;
		tail_d     = tail_q;
		opt_d      = opt_q;
		bump_d     = bump_q;
		ovf_d      = ovf_q;
		res.out_byte   = in_byte;
		res.name_valid = 1'b0;
		res.name_char  = 8'h00;
		res.done_res   = 1'b0;
		res.status     = ST_OK;

		if (pos_q < POS_MAX) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_W'(POS_FLAGS) && in_byte[7]) hdr_bad_d = 1'b1;
					if (pos_q == POS_W'(POS_QD_HI) && in_byte != 8'd0) hdr_bad_d = 1'b1;
					if (pos_q == POS_W'(POS_QD_LO) && in_byte != 8'd1) hdr_bad_d = 1'b1;
					if ((pos_q == POS_W'(POS_AR_HI) || pos_q == POS_W'(POS_AR_LO))
							&& in_byte != 8'd0) ar_d = 1'b1;
					if (pos_q == POS_W'(POS_AR_LO)) phase_d = hdr_bad_q ? PH_IGNORE : PH_LEN;
				end
				PH_LEN: begin
					// dot closing the previous label rides on this byte
					if (used_q != 10'd0) begin
						res.name_valid = 1'b1;
						res.name_char  = DOT_CHAR;
					end
					if (in_byte == 8'd0) begin
						phase_d = PH_TAIL;
						tail_d  = 4'd0;
					end else if (len_sum > {1'b0, max_len_q}) begin
						ovf_d   = 1'b1;
						phase_d = PH_IGNORE;
					end else begin
						used_d     = len_sum[9:0];
						lbl_left_d = in_byte;
						phase_d    = PH_LABEL;
					end
				end
				PH_LABEL: begin
					res.name_valid = 1'b1;
					res.name_char  = in_byte;
					lbl_left_d     = lbl_dec;
					if (lbl_dec == 8'd0) phase_d = PH_LEN;
				end
				PH_TAIL: begin
					unique case (tail_q)
						TAIL_OPT_NAME: opt_d = ar_q && in_byte == 8'd0;
						TAIL_TYPE_HI:  if (in_byte != 8'd0) opt_d = 1'b0;
						TAIL_TYPE_LO:  if (in_byte != OPT_TYPE_LO) opt_d = 1'b0;
						TAIL_SIZE_HI: begin
							if (opt_q && !in_last && in_byte < UDP_SIZE_HI) begin
								res.out_byte = UDP_SIZE_HI;
								bump_d       = 1'b1;
							end
						end
						TAIL_SIZE_LO: begin
							if (bump_q) res.out_byte = 8'h00;
							phase_d = PH_IGNORE;
						end
						default: ;
					endcase
					tail_d = tail_q + 4'd1;
				end
				default: ;
			endcase
			pos_d = pos_q + POS_W'(1);
		end

		if (in_last) begin
			res.done_res = 1'b1;
			if (pos_q < POS_W'(POS_AR_LO)) res.status = ST_SHORT;
			else if (hdr_bad_q)            res.status = ST_NOT_ONE;
			else if (ovf_q)                res.status = ST_NAME_OVF;
			else                           res.status = ST_OK;
			pos_d      = '0;
			phase_d    = PH_HEADER;
			lbl_left_d = '0;
			used_d     = '0;
			hdr_bad_d  = 1'b0;
			ar_d       = 1'b0;
			tail_d     = '0;
			opt_d      = 1'b0;
			bump_d     = 1'b0;
			ovf_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= NAME_LEN_RST;
			pos_q      <= '0;
			phase_q    <= PH_HEADER;
			lbl_left_q <= '0;
			used_q     <= '0;
			hdr_bad_q  <= 1'b0;
			ar_q       <= 1'b0;
			tail_q     <= '0;
			opt_q      <= 1'b0;
			bump_q     <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg_we) max_len_q <= cfg_wdata;
			if (in_fire) begin
				pos_q      <= pos_d;
				phase_q    <= phase_d;
				lbl_left_q <= lbl_left_d;
				used_q     <= used_d;
				hdr_bad_q  <= hdr_bad_d;
				ar_q       <= ar_d;
				tail_q     <= tail_d;
				opt_q      <= opt_d;
				bump_q     <= bump_d;
				ovf_q      <= ovf_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/dqp_queue.sv
// ----------------------------------------------------------------------------
// dqp_queue: two-entry result queue
// Decouples the parser from the output; the head entry drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_queue import dqp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_data,
	output logic      not_full,
	output logic      not_empty,
	input  wire logic pop,
	output res_t      head
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full  = count_q != 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

>>> design/dns_query_parser.sv
// ----------------------------------------------------------------------------
// dns_query_parser: DNS query header check, name walk and EDNS0 size fix-up
// Passes each query byte on, emits the dotted question name, raises a small
// EDNS0 UDP buffer size to 4096 and reports a status on the last byte.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                 | tuser      | tlast
//  ---------+-----+------------------------------------+------------+----------
//  s_axis   | in  | data_byte[7:0]                     | -          | last_byte
//  m_axis   | out | out_byte, name_char, status, pad   | name_valid | done_res
//  cfg      | in  | cfg_wdata = max_name_length[9:0]   | -          | -
//
//  One word in gives exactly one word out. A word is parsed in the cycle it
//  is accepted and lands in a two-entry queue; the queue head is the output,
//  and the sustained rate is one word per clock while m_axis_tready is high.
//  s_axis_tready drops only while both queue entries are occupied.
//  Reset clears all parse state and sets max_name_length to 512.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_parser import dqp_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        cfg_we,
	input  wire logic [9:0]  cfg_wdata,     // max_name_length
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tlast,  // last_byte
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [7:0] out_byte, [15:8] name_char,
	                                        // [17:16] status, [23:18] zero
	output logic             m_axis_tuser,  // name_valid
	output logic             m_axis_tlast   // done_res
);

	logic in_fire;
	logic out_fire;
	logic q_not_full;
	logic q_not_empty;
	res_t front_res;
	res_t q_head;

	assign s_axis_tready = q_not_full;
	assign in_fire       = s_axis_tvalid && q_not_full;
	assign m_axis_tvalid = q_not_empty;
	assign out_fire      = q_not_empty && m_axis_tready;

	// front: header check, label walk, OPT record rewrite
	dqp_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_fire  (in_fire),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.res      (front_res)
	);

	// back: result queue, head is presented on m_axis
	dqp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_fire),
		.push_data(front_res),
		.not_full (q_not_full),
		.not_empty(q_not_empty),
		.pop      (out_fire),
		.head     (q_head)
	);

	assign m_axis_tdata = {6'd0, q_head.status, q_head.name_char, q_head.out_byte};
	assign m_axis_tuser = q_head.name_valid;
	assign m_axis_tlast = q_head.done_res;

	// status is only reported on the closing word
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[17:16] == 2'd0)
		else $error("status set on a non-final word");

	// name_char is zero when no name character is flagged
	a_char_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] == 8'd0)
		else $error("name_char set without name_valid");

	// input backpressure only when results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty queue");

	// a word accepted into an empty queue shows on the output next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !m_axis_tvalid |=> m_axis_tvalid)
		else $error("accepted word did not reach the output");

endmodule

`default_nettype wire
